>>> src/orf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_pkg
// Shared types and constants of the overwrite-oldest ring FIFO.
// ----------------------------------------------------------------------------
package orf_pkg;

  localparam int CNT_W = 5;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               underflow;
    logic               overwrote;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
    logic               is_full;
  } out_t;

  // status of one transaction, handed from the pointer logic to the output side
  typedef struct packed {
    logic             rd;
    logic             underflow;
    logic             overwrote;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } status_t;

endpackage

>>> src/orf_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orf_mem
// Word store of the ring FIFO: one write and one read port, registered read.
// ----------------------------------------------------------------------------
module orf_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [DATA_WIDTH-1:0]        wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [DATA_WIDTH-1:0]        rdata_r
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/orf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orf_ctrl
// Head, tail, count and capacity registers; issues the memory accesses.
// ----------------------------------------------------------------------------
module orf_ctrl
  import orf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CNT_W-1:0]         cfg_capacity,
  input  wire logic                     op_valid,
  input  wire opcode_t                  op,
  output logic                          mem_we,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output logic                          mem_re,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr,
  output status_t                       stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CMP_W = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int CAP_LIM = (DEPTH > 31) ? 31 : DEPTH;
  localparam int CAP_RST = (DEPTH > 16) ? 16 : DEPTH;

  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [AW-1:0]    head_adv, tail_adv;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [CNT_W-1:0] cap);
    logic [CMP_W-1:0] nx;
    nx = CMP_W'(idx) + CMP_W'(1);
    return (nx >= CMP_W'(cap)) ? '0 : nx[AW-1:0];
  endfunction

  // clamp the written capacity into 1..DEPTH, and to at most 31
  always_comb begin
    if (cfg_capacity == '0) begin
      cap_nxt = CNT_W'(1);
    end else if (cfg_capacity > CNT_W'(CAP_LIM)) begin
      cap_nxt = CNT_W'(CAP_LIM);
    end else begin
      cap_nxt = cfg_capacity;
    end
  end

  assign head_adv = advance(head_r, cap_r);
  assign tail_adv = advance(tail_r, cap_r);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    stat.rd        = 1'b0;
    stat.underflow = 1'b0;
    stat.overwrote = 1'b0;
    case (op) inside
      OP_PUSH: begin
        mem_we   = op_valid;
        tail_nxt = tail_adv;
        if (cnt_r < cap_r) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          head_nxt       = head_adv;
          stat.overwrote = 1'b1;
        end
      end
      OP_POP, OP_PEEK: begin
        if (cnt_r == '0) begin
          stat.underflow = 1'b1;
        end else begin
          stat.rd = 1'b1;
          mem_re  = op_valid;
          if (op == OP_POP) begin
            head_nxt = head_adv;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    stat.count    = cnt_nxt;
    stat.is_empty = (cnt_nxt == '0);
    stat.is_full  = (cnt_nxt == cap_r);
  end

  assign mem_waddr = tail_r;
  assign mem_raddr = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      cap_r  <= CNT_W'(CAP_RST);
    end else if (cfg_we) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      cap_r  <= cap_nxt;
    end else if (op_valid) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/overwrite_ring_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_ring_fifo_unit
// Circular FIFO of signed words that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// Input transactions (in_valid/in_ready, in_data) carry a push, pop or peek;
// each gives one status transaction on out_valid/out_ready/out_data.
// A push stores at the tail; on a full buffer it replaces the oldest entry
// and flags overwrote. Pop and peek return the oldest word, or 0 with
// underflow set when the buffer is empty.
// The cfg channel writes the capacity (clamped to 1..DEPTH, at most 31) and
// empties the buffer; it is always ready and is meant to be used while the unit is idle.
// The accepting edge updates the pointers and registers the memory read;
// the output register loads from that stage once it is free or being read.
// Throughput: one transaction per cycle while the receiver takes results;
// the pointers update at accept, so back-to-back items see each other's
// effect without waiting.
// When the receiver stalls, the output register and the stage behind it
// fill and in_ready drops; no transaction is lost.
// Reset empties the buffer and sets the capacity to 16 (or DEPTH if smaller);
// stored words are not cleared and no pass over the memory is needed.
// ----------------------------------------------------------------------------
module overwrite_ring_fifo_unit
  import orf_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);

  logic                  in_fire;
  logic                  cfg_fire;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  logic [WORD_W-1:0]     rd_word;
  status_t               stat;
  status_t               s1_stat_r;
  logic                  s1_valid_r;
  logic                  s1_go;
  logic                  out_valid_r;
  out_t                  out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_fire   = in_valid & in_ready;

  orf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_fire),
    .cfg_capacity (cfg_data),
    .op_valid     (in_fire),
    .op           (in_data.opcode),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .stat         (stat)
  );

  orf_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // fit the word into the stored width; a narrower store is sign-extended back out
  generate
    if (DATA_WIDTH > WORD_W) begin : g_wide
      assign mem_wdata = {{(DATA_WIDTH - WORD_W){1'b0}}, in_data.push_value};
      assign rd_word   = mem_rdata[WORD_W-1:0];
    end else if (DATA_WIDTH == WORD_W) begin : g_equal
      assign mem_wdata = in_data.push_value;
      assign rd_word   = mem_rdata;
    end else begin : g_narrow
      assign mem_wdata = in_data.push_value[DATA_WIDTH-1:0];
      assign rd_word   = {{(WORD_W - DATA_WIDTH){mem_rdata[DATA_WIDTH-1]}}, mem_rdata};
    end
  endgenerate

  assign s1_go    = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_go;

  always_comb begin
    out_data_nxt.read_value = s1_stat_r.rd ? rd_word : '0;
    out_data_nxt.underflow  = s1_stat_r.underflow;
    out_data_nxt.overwrote  = s1_stat_r.overwrote;
    out_data_nxt.count      = s1_stat_r.count;
    out_data_nxt.is_empty   = s1_stat_r.is_empty;
    out_data_nxt.is_full    = s1_stat_r.is_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_stat_r <= stat;
    end
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
